>>> design/sbts_pkg.sv
// Package for the sorted bitrate table select block.
// Holds field widths, action codes and the sequencer state type; no dependencies.
package sbts_pkg;

   localparam int RATE_W         = 24;
   localparam int TPUT_W         = 32;
   localparam int ACTION_W       = 2;
   localparam int STORED_COUNT_W = 5;
   localparam int REQ_DATA_W     = 56;
   localparam int RSP_DATA_W     = 32;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SELECT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_SEL_RD,
      ST_SEL_CMP,
      ST_DONE
   } state_type;

endpackage

>>> design/sbts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; width and depth are parameters.
module sbts_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/sorted_bitrate_table_select.sv
// Top level of the sorted bitrate table select block.
// Depends on sbts_pkg and sbts_ram.
//
// The block keeps an ascending table of up to MAX_RATES bitrates in a RAM and
// handles one transfer at a time, with req_tready high only while idle. A
// single read port and one 3*rate versus 2*throughput comparator are stepped
// by a small sequencer, one table entry visited at a time. An insert walks
// down from the top of the table, moving each larger or equal entry up one
// slot, until it reaches the insert position or the bottom slot. A select
// walks up from the smallest entry and stops at the first entry that fails
// the comparison or after the last one. Clear, unused codes, a full-table
// insert and a select on an empty table visit no table entry. A finished
// result waits in an output register, so the next request transfer is taken
// while it is still pending; the result of that next item then waits in the
// sequencer until rsp_tready frees the output register.
module sorted_bitrate_table_select #(
   parameter int MAX_RATES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: new_rate [23:0], throughput [55:24].
   input  logic [sbts_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: action [1:0].
   input  logic [sbts_pkg::ACTION_W-1:0]      req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // rsp_tdata: chosen_rate [23:0], table_empty [24], insert_dropped [25],
   // stored_count [30:26], zero [31].
   output logic [sbts_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready
);

   localparam int ADDR_W = $clog2(MAX_RATES);
   localparam int CNT_W  = $clog2(MAX_RATES + 1);
   localparam int LIM_W  = sbts_pkg::TPUT_W + 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RATES);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   sbts_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]                count_ff, count_in;
   logic [CNT_W-1:0]                idx_ff, idx_in;
   logic [sbts_pkg::RATE_W-1:0]     rate_ff, rate_in;
   logic [LIM_W-1:0]                limit_ff, limit_in;
   logic [sbts_pkg::RATE_W-1:0]     best_ff, best_in;
   logic                            dropped_ff, dropped_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sbts_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                            ram_wr_en;
   logic [ADDR_W-1:0]               ram_wr_addr;
   logic [sbts_pkg::RATE_W-1:0]     ram_wr_data;
   logic [ADDR_W-1:0]               ram_rd_addr;
   logic [sbts_pkg::RATE_W-1:0]     ram_rd_data;

   logic [sbts_pkg::RATE_W+1:0]     triple;
   logic                            rate_pass;
   logic [CNT_W-1:0]                idx_dec;
   logic [CNT_W-1:0]                idx_inc;
   logic [sbts_pkg::STORED_COUNT_W-1:0] stored_count;

   sbts_ram #(
      .WIDTH(sbts_pkg::RATE_W),
      .DEPTH(MAX_RATES)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign triple    = {2'b00, ram_rd_data} + {1'b0, ram_rd_data, 1'b0};
   assign rate_pass = LIM_W'(triple) <= limit_ff;
   assign idx_dec   = idx_ff - CNT_ONE;
   assign idx_inc   = idx_ff + CNT_ONE;

   generate
      if (CNT_W >= sbts_pkg::STORED_COUNT_W) begin : g_cnt_trunc
         assign stored_count = count_ff[sbts_pkg::STORED_COUNT_W-1:0];
      end else begin : g_cnt_ext
         assign stored_count = {{(sbts_pkg::STORED_COUNT_W-CNT_W){1'b0}}, count_ff};
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rate_in      = rate_ff;
      limit_in     = limit_ff;
      best_in      = best_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff[ADDR_W-1:0];
      ram_wr_data  = rate_ff;
      ram_rd_addr  = idx_ff[ADDR_W-1:0];
      req_tready   = 1'b0;

      unique case (state_ff)
         sbts_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rate_in    = req_tdata[sbts_pkg::RATE_W-1:0];
               limit_in   = {req_tdata[sbts_pkg::REQ_DATA_W-1:sbts_pkg::RATE_W], 1'b0};
               best_in    = '0;
               dropped_in = 1'b0;
               idx_in     = count_ff;
               state_in   = sbts_pkg::ST_DONE;
               unique case (req_tuser)
                  sbts_pkg::ACT_INSERT: begin
                     if (count_ff == CNT_MAX) begin
                        dropped_in = 1'b1;
                     end else begin
                        state_in = sbts_pkg::ST_INS_RD;
                     end
                  end
                  sbts_pkg::ACT_SELECT: begin
                     idx_in = '0;
                     if (count_ff != '0) begin
                        state_in = sbts_pkg::ST_SEL_RD;
                     end
                  end
                  sbts_pkg::ACT_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         sbts_pkg::ST_INS_RD: begin
            if (idx_ff == '0) begin
               ram_wr_en = 1'b1;
               count_in  = count_ff + CNT_ONE;
               state_in  = sbts_pkg::ST_DONE;
            end else begin
               ram_rd_addr = idx_dec[ADDR_W-1:0];
               state_in    = sbts_pkg::ST_INS_CMP;
            end
         end
         sbts_pkg::ST_INS_CMP: begin
            ram_wr_en = 1'b1;
            if (ram_rd_data >= rate_ff) begin
               ram_wr_data = ram_rd_data;
               idx_in      = idx_dec;
               state_in    = sbts_pkg::ST_INS_RD;
            end else begin
               count_in = count_ff + CNT_ONE;
               state_in = sbts_pkg::ST_DONE;
            end
         end
         sbts_pkg::ST_SEL_RD: begin
            state_in = sbts_pkg::ST_SEL_CMP;
         end
         sbts_pkg::ST_SEL_CMP: begin
            if (rate_pass || idx_ff == '0) begin
               best_in = ram_rd_data;
            end
            if (rate_pass && idx_inc != count_ff) begin
               idx_in   = idx_inc;
               state_in = sbts_pkg::ST_SEL_RD;
            end else begin
               state_in = sbts_pkg::ST_DONE;
            end
         end
         sbts_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, stored_count, dropped_ff, count_ff == '0, best_ff};
               state_in     = sbts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sbts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbts_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      rate_ff     <= rate_in;
      limit_ff    <= limit_in;
      best_ff     <= best_in;
      dropped_ff  <= dropped_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> dv/sorted_bitrate_table_select_tb.sv
// Testbench for sorted_bitrate_table_select: directed and random insert, select and clear traffic.
// Depends on sbts_pkg and the design; predicts each response with its own table model.
`timescale 1ns / 100ps

module sorted_bitrate_table_select_tb;

   localparam int TABLE_DEPTH = 16;
   localparam int RANDOM_ITEMS = 610;
   localparam int DRAIN_EARLY = 25;
   localparam int DRAIN_LATE = 350;
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT = 500000;
   localparam logic [sbts_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [sbts_pkg::ACTION_W-1:0] action;
      logic [sbts_pkg::RATE_W-1:0]   new_rate;
      logic [sbts_pkg::TPUT_W-1:0]   throughput;
   } rate_request_type;

   typedef struct packed {
      logic [sbts_pkg::RATE_W-1:0]         chosen_rate;
      logic                                table_empty;
      logic                                insert_dropped;
      logic [sbts_pkg::STORED_COUNT_W-1:0] stored_count;
   } rate_response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [sbts_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [sbts_pkg::ACTION_W-1:0]   req_tuser = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [sbts_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;

   rate_request_type  pending_requests[$];
   rate_response_type awaited_responses[$];
   rate_request_type  in_flight;
   rate_response_type observed;
   rate_response_type wanted;

   logic [sbts_pkg::RATE_W-1:0] rate_shadow[TABLE_DEPTH];
   int                          rate_fill = 0;
   logic [sbts_pkg::RATE_W-1:0] issued_rates[$];

   int          accepted_count = 0;
   int          burst_left = 1;
   int          gap_left = 0;
   int          stall_mode = 0;
   int          stall_phase_left = 0;
   int          mismatch_count = 0;
   int unsigned cycle_count = 0;
   int          random_total;
   int          roll;
   logic [sbts_pkg::RATE_W-1:0] pick_rate;
   logic [sbts_pkg::TPUT_W-1:0] pick_tput;
   logic [sbts_pkg::TPUT_W-1:0] boundary;

   sorted_bitrate_table_select #(.MAX_RATES(TABLE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #4 clock = ~clock;

   function automatic rate_response_type apply_request(rate_request_type req);
      rate_response_type res;
      int pos;
      int idx;
      logic [33:0] tput_twice;
      res = '0;
      tput_twice = {1'b0, req.throughput, 1'b0};
      case (req.action)
         sbts_pkg::ACT_INSERT: begin
            if (rate_fill >= TABLE_DEPTH) begin
               res.insert_dropped = 1'b1;
            end else begin
               pos = 0;
               while (pos < rate_fill && rate_shadow[pos] < req.new_rate) pos++;
               for (idx = rate_fill; idx > pos; idx--) rate_shadow[idx] = rate_shadow[idx - 1];
               rate_shadow[pos] = req.new_rate;
               rate_fill++;
            end
         end
         sbts_pkg::ACT_SELECT: begin
            if (rate_fill != 0) begin
               res.chosen_rate = rate_shadow[0];
               for (idx = 0; idx < rate_fill; idx++) begin
                  if (34'(rate_shadow[idx]) * 34'd3 <= tput_twice) begin
                     res.chosen_rate = rate_shadow[idx];
                  end else begin
                     break;
                  end
               end
            end
         end
         sbts_pkg::ACT_CLEAR: begin
            rate_fill = 0;
         end
         default: begin
         end
      endcase
      res.table_empty = (rate_fill == 0);
      res.stored_count = sbts_pkg::STORED_COUNT_W'(rate_fill);
      return res;
   endfunction

   task automatic add_request(logic [sbts_pkg::ACTION_W-1:0] action,
                              logic [sbts_pkg::RATE_W-1:0] rate,
                              logic [sbts_pkg::TPUT_W-1:0] tput);
      rate_request_type req;
      req.action = action;
      req.new_rate = rate;
      req.throughput = tput;
      pending_requests.push_back(req);
      if (action == sbts_pkg::ACT_CLEAR) begin
         issued_rates.delete();
      end else if (action == sbts_pkg::ACT_INSERT && issued_rates.size() < TABLE_DEPTH) begin
         issued_rates.push_back(rate);
      end
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  awaited_responses.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_responses.push_back(apply_request(in_flight));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() == 0 ||
                         ((accepted_count == DRAIN_EARLY || accepted_count == DRAIN_LATE) &&
                          awaited_responses.size() != 0)) begin
               req_tvalid <= 1'b0;
            end else begin
               in_flight = pending_requests.pop_front();
               req_tdata <= {in_flight.throughput, in_flight.new_rate};
               req_tuser <= in_flight.action;
               req_tvalid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(1, 10);
                  case ($urandom_range(0, 5))
                     0, 1: gap_left = 0;
                     2: gap_left = $urandom_range(15, 40);
                     default: gap_left = $urandom_range(1, 6);
                  endcase
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (stall_phase_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_phase_left = $urandom_range(16, 96);
         end else begin
            stall_phase_left--;
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= (cycle_count[1:0] == 2'd0);
            default: rsp_tready <= ($urandom_range(0, 15) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         observed.chosen_rate = rsp_tdata[23:0];
         observed.table_empty = rsp_tdata[24];
         observed.insert_dropped = rsp_tdata[25];
         observed.stored_count = rsp_tdata[30:26];
         if (awaited_responses.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response, expected none, got %0h", $time, rsp_tdata);
         end else begin
            wanted = awaited_responses.pop_front();
            check_field("chosen_rate", 32'(wanted.chosen_rate), 32'(observed.chosen_rate));
            check_field("table_empty", 32'(wanted.table_empty), 32'(observed.table_empty));
            check_field("insert_dropped", 32'(wanted.insert_dropped),
                        32'(observed.insert_dropped));
            check_field("stored_count", 32'(wanted.stored_count), 32'(observed.stored_count));
         end
      end
   end

   initial begin
      // Empty table, duplicates, both sides of the 1.5 boundary, filling past the top, unused code.
      add_request(sbts_pkg::ACT_SELECT, 24'h5A5A5A, 32'hFFFFFFFF);
      add_request(sbts_pkg::ACT_CLEAR, 24'hFFFFFF, 32'hFFFFFFFF);
      add_request(sbts_pkg::ACT_INSERT, 24'hFFFFFF, 32'h0);
      add_request(sbts_pkg::ACT_INSERT, 24'd3, 32'hFFFFFFFF);
      add_request(sbts_pkg::ACT_INSERT, 24'd3, 32'h0);
      add_request(sbts_pkg::ACT_SELECT, 24'h0, 32'd4);
      add_request(sbts_pkg::ACT_SELECT, 24'hFFFFFF, 32'd5);
      add_request(sbts_pkg::ACT_SELECT, 24'h0, 32'hFFFFFFFF);
      add_request(sbts_pkg::ACT_INSERT, 24'h000000, 32'h0);
      add_request(sbts_pkg::ACT_INSERT, 24'h000001, 32'h0);
      add_request(sbts_pkg::ACT_INSERT, 24'h555555, 32'h0);
      add_request(sbts_pkg::ACT_INSERT, 24'hAAAAAA, 32'h0);
      add_request(sbts_pkg::ACT_INSERT, 24'h7FFFFF, 32'h0);
      add_request(sbts_pkg::ACT_INSERT, 24'h800000, 32'h0);
      add_request(sbts_pkg::ACT_INSERT, 24'hFFFFFF, 32'h0);
      add_request(sbts_pkg::ACT_INSERT, 24'h000002, 32'h0);
      add_request(sbts_pkg::ACT_INSERT, 24'h000003, 32'h0);
      add_request(sbts_pkg::ACT_INSERT, 24'h00FFFF, 32'h0);
      add_request(sbts_pkg::ACT_INSERT, 24'hFFFFFE, 32'h0);
      add_request(sbts_pkg::ACT_INSERT, 24'h000000, 32'h0);
      add_request(sbts_pkg::ACT_INSERT, 24'h123456, 32'h0);
      add_request(sbts_pkg::ACT_INSERT, 24'h654321, 32'h0);
      add_request(ACT_UNUSED, 24'hFFFFFF, 32'hFFFFFFFF);
      add_request(sbts_pkg::ACT_SELECT, 24'h0, 32'h0);
      add_request(sbts_pkg::ACT_CLEAR, 24'h0, 32'h0);

      random_total = 0;
      while (random_total < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         case ($urandom_range(0, 3))
            0: pick_rate = sbts_pkg::RATE_W'($urandom_range(0, 15));
            1: pick_rate = sbts_pkg::RATE_W'($urandom());
            2: pick_rate = (issued_rates.size() != 0) ?
                  issued_rates[$urandom_range(0, issued_rates.size() - 1)] :
                  sbts_pkg::RATE_W'($urandom());
            default: pick_rate = 24'hFFFFFF - sbts_pkg::RATE_W'($urandom_range(0, 15));
         endcase
         boundary = (32'(pick_rate) * 32'd3 + 32'd1) / 32'd2;
         case ($urandom_range(0, 5))
            0, 1, 2: pick_tput = boundary - 32'($urandom_range(0, 1));
            3: pick_tput = $urandom();
            4: pick_tput = 32'($urandom_range(0, 64));
            default: pick_tput = 32'hFFFFFFFF - 32'($urandom_range(0, 64));
         endcase
         if (roll < 3) begin
            add_request(sbts_pkg::ACT_CLEAR, sbts_pkg::RATE_W'($urandom()), $urandom());
            random_total++;
         end else if (roll < 6) begin
            add_request(ACT_UNUSED, sbts_pkg::RATE_W'($urandom()), $urandom());
         end else if (roll < 56) begin
            add_request(sbts_pkg::ACT_INSERT, pick_rate, $urandom());
            random_total++;
         end else begin
            add_request(sbts_pkg::ACT_SELECT, sbts_pkg::RATE_W'($urandom()), pick_tput);
            random_total++;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_tvalid || awaited_responses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
design/sbts_pkg.sv
design/sbts_ram.sv
design/sorted_bitrate_table_select.sv
dv/sorted_bitrate_table_select_tb.sv
